### hw/rtl/rmd_pkg.sv
// Package for the RIPEMD-320 hash block: types, round constants and tables.
// Used by every module of the block; depends on nothing.
`default_nettype none
package rmd_pkg;

   // Request as it travels from the front end to the compression engine.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       finish;
   } req_type;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueAw = 2;

   function automatic logic [31:0] init_word(input logic [3:0] idx);
      logic [31:0] w;
      case (idx)
         4'd0: w = 32'h67452301;
         4'd1: w = 32'hefcdab89;
         4'd2: w = 32'h98badcfe;
         4'd3: w = 32'h10325476;
         4'd4: w = 32'hc3d2e1f0;
         4'd5: w = 32'h76543210;
         4'd6: w = 32'hfedcba98;
         4'd7: w = 32'h89abcdef;
         4'd8: w = 32'h01234567;
         default: w = 32'h3c2d1e0f;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] add_left(input logic [2:0] rd);
      logic [31:0] k;
      case (rd)
         3'd0: k = 32'h00000000;
         3'd1: k = 32'h5a827999;
         3'd2: k = 32'h6ed9eba1;
         3'd3: k = 32'h8f1bbcdc;
         default: k = 32'ha953fd4e;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] add_right(input logic [2:0] rd);
      logic [31:0] k;
      case (rd)
         3'd0: k = 32'h50a28be6;
         3'd1: k = 32'h5c4dd124;
         3'd2: k = 32'h6d703ef3;
         3'd3: k = 32'h7a6d76e9;
         default: k = 32'h00000000;
      endcase
      return k;
   endfunction

   localparam logic [3:0] WordLeft [80] = '{
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15,
      7, 4,13, 1,10, 6,15, 3,12, 0, 9, 5, 2,14,11, 8,
      3,10,14, 4, 9,15, 8, 1, 2, 7, 0, 6,13,11, 5,12,
      1, 9,11,10, 0, 8,12, 4,13, 3, 7,15,14, 5, 6, 2,
      4, 0, 5, 9, 7,12, 2,10,14, 1, 3, 8,11, 6,15,13};
   localparam logic [3:0] WordRight [80] = '{
      5,14, 7, 0, 9, 2,11, 4,13, 6,15, 8, 1,10, 3,12,
      6,11, 3, 7, 0,13, 5,10,14,15, 8,12, 4, 9, 1, 2,
     15, 5, 1, 3, 7,14, 6, 9,11, 8,12, 2,10, 0, 4,13,
      8, 6, 4, 1, 3,11,15, 0, 5,12, 2,13, 9, 7,10,14,
     12,15,10, 4, 1, 5, 8, 7, 6, 2,13,14, 0, 3, 9,11};
   localparam logic [4:0] RotLeft [80] = '{
     11,14,15,12, 5, 8, 7, 9,11,13,14,15, 6, 7, 9, 8,
      7, 6, 8,13,11, 9, 7,15, 7,12,15, 9,11, 7,13,12,
     11,13, 6, 7,14, 9,13,15,14, 8,13, 6, 5,12, 7, 5,
     11,12,14,15,14,15, 9, 8, 9,14, 5, 6, 8, 6, 5,12,
      9,15, 5,11, 6, 8,13,12, 5,12,13,14,11, 8, 5, 6};
   localparam logic [4:0] RotRight [80] = '{
      8, 9, 9,11,13,15,15, 5, 7, 7, 8,11,14,14,12, 6,
      9,13,15, 7,12, 8, 9,11, 7, 7,12, 7, 6,15,13,11,
      9, 7,15,11, 8, 6, 6,14,12,13, 5,14,13,13, 7, 5,
     15, 5, 8,11,14,14, 6,14, 6, 9,12, 9,12, 5,15, 8,
      8, 5,12, 9,12, 5,14, 6, 8,13, 6, 5,15,13,11,11};

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] bool_fn(input logic [2:0] sel, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z);
      logic [31:0] f;
      case (sel)
         3'd0: f = x ^ y ^ z;
         3'd1: f = (x & y) | (~x & z);
         3'd2: f = (x | ~y) ^ z;
         3'd3: f = (x & z) | (y & ~z);
         default: f = x ^ (y | ~z);
      endcase
      return f;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/rmd_queue.sv
// Short request queue between the front end and the compression engine.
// Depends on rmd_pkg.
`default_nettype none
module rmd_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            wr_en,
   input  wire rmd_pkg::req_type wr_data,
   output logic                 full,
   input  wire logic            rd_en,
   output rmd_pkg::req_type     rd_data,
   output logic                 empty
);
   import rmd_pkg::*;

   req_type            slot_ff [QueueDepth];
   logic [QueueAw-1:0] wptr_ff, rptr_ff;
   logic [QueueAw:0]   count_ff;

   assign full    = (count_ff == QueueAw'(0) + (QueueAw+1)'(QueueDepth));
   assign empty   = (count_ff == '0);
   assign rd_data = slot_ff[rptr_ff];

   // Storage slots hold payload only.
   always_ff @(posedge clock) begin
      if (wr_en && !full) slot_ff[wptr_ff] <= wr_data;
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (wr_en && !full) wptr_ff <= wptr_ff + 1'b1;
         if (rd_en && !empty) rptr_ff <= rptr_ff + 1'b1;
         count_ff <= count_ff + (QueueAw+1)'(wr_en && !full)
                     - (QueueAw+1)'(rd_en && !empty);
      end
   end
endmodule
`default_nettype wire

### hw/rtl/rmd_engine.sv
// Back end: block buffer, padding, 80-step two-line compression, digest output.
// Depends on rmd_pkg.
`default_nettype none
module rmd_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rmd_pkg::req_type q_data,
   input  wire logic             q_empty,
   output logic                  q_pop,
   output logic [31:0]           rsp_digest_word,
   output logic [3:0]            rsp_word_index,
   output logic                  rsp_last_word,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop
);
   import rmd_pkg::*;

   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StPad   = 3'd1;
   localparam logic [2:0] StRound = 3'd2;
   localparam logic [2:0] StAdd   = 3'd3;
   localparam logic [2:0] StEmit  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] blk_ff [16];   // message block as little-endian words
   logic [5:0]  fill_ff;
   logic [63:0] total_ff;
   logic [31:0] chain_ff [10];
   logic [31:0] t_ff [10];
   logic [6:0]  step_ff;
   logic [2:0]  phase_ff;      // step number modulo 5
   logic [5:0]  pad_ff;
   logic        pad_more_ff;  // a second, length-bearing block follows
   logic        padded_ff;    // the padded block of this finish is in the buffer
   logic        fin_ff;       // compression belongs to a finish
   logic [3:0]  emit_ff;
   logic        out_valid_ff;

   // Per-step decode.
   logic [2:0]  rd;
   logic [3:0]  j;
   logic [31:0] xl, xr, fl, fr, al, ar;
   logic [3:0]  rdi;
   logic [3:0]  ia, ib, ic, id, ie;
   logic [31:0] t_step [10];
   logic [31:0] swap_word;

   // Reduces a value below ten into the range 0..4.
   function automatic logic [3:0] wrap5(input logic [3:0] v);
      return (v >= 4'd5) ? v - 4'd5 : v;
   endfunction

   always_comb begin
      rd  = 3'(step_ff >> 4);
      j   = step_ff[3:0];
      rdi = {1'b0, rd};
      // Word roles rotate by one position every step.
      ia = wrap5(4'd5 - {1'b0, phase_ff});
      ib = wrap5(4'd6 - {1'b0, phase_ff});
      ic = wrap5(4'd7 - {1'b0, phase_ff});
      id = wrap5(4'd8 - {1'b0, phase_ff});
      ie = wrap5(4'd9 - {1'b0, phase_ff});
      xl = blk_ff[WordLeft[step_ff]];
      xr = blk_ff[WordRight[step_ff]];
      fl = bool_fn(rd, t_ff[ib], t_ff[ic], t_ff[id]) + t_ff[ia] + xl + add_left(rd);
      fr = bool_fn(3'd4 - rd, t_ff[ib + 4'd5], t_ff[ic + 4'd5], t_ff[id + 4'd5])
           + t_ff[ia + 4'd5] + xr + add_right(rd);
      al = rotl(fl, RotLeft[step_ff]) + t_ff[ie];
      ar = rotl(fr, RotRight[step_ff]) + t_ff[ie + 4'd5];
      // Working words after this step of both lines.
      for (int i = 0; i < 10; i++) t_step[i] = t_ff[i];
      t_step[ia]        = al;
      t_step[ic]        = rotl(t_ff[ic], 5'd10);
      t_step[ia + 4'd5] = ar;
      t_step[ic + 4'd5] = rotl(t_ff[ic + 4'd5], 5'd10);
      // Line swap of one word at the end of each round.
      swap_word = t_step[rdi];
      if (j == 4'd15) begin
         t_step[rdi]        = t_step[rdi + 4'd5];
         t_step[rdi + 4'd5] = swap_word;
      end
   end

   assign q_pop           = (state_ff == StIdle) && !q_empty;
   assign rsp_empty       = !out_valid_ff;
   assign rsp_digest_word = chain_ff[emit_ff];
   assign rsp_word_index  = emit_ff;
   assign rsp_last_word   = (emit_ff == 4'd9);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle:  if (!q_empty) begin
            if (q_data.byte_present && fill_ff == 6'd63) state_in = StRound;
            else if (q_data.finish) state_in = StPad;
         end
         StPad:   state_in = StRound;
         StRound: if (step_ff == 7'd79) state_in = StAdd;
         StAdd:   state_in = !fin_ff ? StIdle
                             : ((!padded_ff || pad_more_ff) ? StPad : StEmit);
         StEmit:  if (rsp_pop && emit_ff == 4'd9) state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   // Datapath and control.
   always_ff @(posedge clock) begin
      logic [63:0] bits;
      logic [31:0] nw;
      logic [7:0]  nb;
      logic [7:0]  len_byte;
      logic [5:0]  pos;
      bits = total_ff << 3;
      if (reset) begin
         state_ff     <= StIdle;
         fill_ff      <= '0;
         total_ff     <= '0;
         step_ff      <= '0;
         phase_ff     <= '0;
         fin_ff       <= 1'b0;
         pad_more_ff  <= 1'b0;
         padded_ff    <= 1'b0;
         emit_ff      <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 10; i++) chain_ff[i] <= init_word(4'(i));
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            StIdle: if (!q_empty) begin
               fin_ff    <= q_data.finish;
               padded_ff <= 1'b0;
               if (q_data.byte_present) begin
                  blk_ff[fill_ff[5:2]][{fill_ff[1:0], 3'b000} +: 8] <= q_data.data_byte;
                  fill_ff  <= fill_ff + 6'd1;
                  total_ff <= total_ff + 64'd1;
               end
               step_ff  <= '0;
               phase_ff <= '0;
               for (int i = 0; i < 10; i++) t_ff[i] <= chain_ff[i];
               // Padding position follows this request's byte, if any.
               pad_ff <= fill_ff + 6'(q_data.byte_present);
            end
            StPad: begin
               // Write the whole padded block in one pass.
               for (int w = 0; w < 16; w++) begin
                  nw = blk_ff[w];
                  for (int l = 0; l < 4; l++) begin
                     pos      = 6'(4*w + l);
                     len_byte = bits[{pos[2:0], 3'b000} +: 8];
                     nb       = nw[8*l +: 8];
                     if (pad_more_ff) nb = (pos >= 6'd56) ? len_byte : 8'h00;
                     else if (pos == pad_ff) nb = 8'h80;
                     else if (pos > pad_ff)
                        nb = (pad_ff < 6'd56 && pos >= 6'd56) ? len_byte : 8'h00;
                     nw[8*l +: 8] = nb;
                  end
                  blk_ff[w] <= nw;
               end
               pad_more_ff <= !pad_more_ff && (pad_ff >= 6'd56);
               padded_ff   <= 1'b1;
               step_ff     <= '0;
               phase_ff    <= '0;
               for (int i = 0; i < 10; i++) t_ff[i] <= chain_ff[i];
            end
            StRound: begin
               for (int i = 0; i < 10; i++) t_ff[i] <= t_step[i];
               step_ff  <= (step_ff == 7'd79) ? 7'd0 : step_ff + 7'd1;
               phase_ff <= (phase_ff == 3'd4) ? 3'd0 : phase_ff + 3'd1;
            end
            StAdd: begin
               for (int i = 0; i < 10; i++) begin
                  t_ff[i]     <= chain_ff[i] + t_ff[i];
                  chain_ff[i] <= chain_ff[i] + t_ff[i];
               end
               fill_ff <= '0;
               emit_ff <= '0;
               if (fin_ff && padded_ff && !pad_more_ff) out_valid_ff <= 1'b1;
            end
            StEmit: if (rsp_pop) begin
               emit_ff <= emit_ff + 4'd1;
               if (emit_ff == 4'd9) begin
                  out_valid_ff <= 1'b0;
                  total_ff     <= '0;
                  for (int i = 0; i < 10; i++) chain_ff[i] <= init_word(4'(i));
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

### hw/rtl/ripemd320_hash.sv
// RIPEMD-320 hash. A request is registered in the queue and taken by the engine
// while it is idle; a byte is stored, a 64th byte also starts a compression (load,
// 80 steps of both lines, fold), a finish pads and compresses, twice when padding
// spills into a second block. Ten digest words then leave at one per cycle as popped; a 4-entry queue lets
// the front accept meanwhile. Synchronous active-high reset restores the initial
// chaining words, empty buffer and zero byte count. Needs rmd_pkg, rmd_queue, rmd_engine.
`default_nettype none
module ripemd320_hash (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_present,
   input  wire logic        req_finish,
   output logic             empty,
   input  wire logic        pop,
   output logic [31:0]      rsp_digest_word,
   output logic [3:0]       rsp_word_index,
   output logic             rsp_last_word
);
   import rmd_pkg::*;

   req_type q_in, q_out;
   logic    q_empty, q_pop;

   // Front end: package the request for the queue.
   assign q_in = '{data_byte: req_data_byte, byte_present: req_byte_present,
                   finish: req_finish};

   rmd_queue u_queue (
      .clock(clock), .reset(reset), .wr_en(push), .wr_data(q_in), .full(full),
      .rd_en(q_pop), .rd_data(q_out), .empty(q_empty)
   );

   rmd_engine u_engine (
      .clock(clock), .reset(reset), .q_data(q_out), .q_empty(q_empty), .q_pop(q_pop),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word), .rsp_empty(empty), .rsp_pop(pop)
   );

   // The last-word flag matches the index.
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_last_word == (rsp_word_index == 4'd9)))
      else $error("last word flag mismatch");

   // A popped word that was not last advances the index by one.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last_word) |=> (rsp_word_index == $past(rsp_word_index) + 4'd1))
      else $error("digest index did not advance");

   // A result appears with index zero first.
   assert property (@(posedge clock) $fell(empty) |-> (rsp_word_index == 4'd0))
      else $error("digest does not start at word zero");
endmodule
`default_nettype wire
